>>> hw/rtl/rstc2_pkg.sv
// Shared types, constants and microcode for the second-order RST regulator.
// Used by every module of the block and the channel interfaces' users.
// Depends on nothing.
`timescale 1ns / 1ps

package rstc2_pkg;

  localparam int SIG_W      = 32;
  localparam int PROD_W     = 2 * SIG_W;
  localparam int ACC_W      = 68;
  localparam int FRAC_W     = 24;
  localparam int HIST_DEPTH = 3;
  localparam int DIV_BITS   = 32;
  localparam int CNT_W      = $clog2(DIV_BITS);
  localparam int PC_W       = 5;
  localparam int CFG_IDX_W  = 3;

  // Q8.24 one, used to lift the applied actuation into the Q.40 sum
  localparam logic signed [SIG_W-1:0] FRAC_ONE = SIG_W'(32'sh0100_0000);
  localparam logic signed [SIG_W-1:0] T0_RESET = FRAC_ONE;

  typedef enum logic [0:0] {
    CMD_STEP = 1'b0,
    CMD_CLIP = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0 = 3'd0,
    CFG_R1 = 3'd1,
    CFG_R2 = 3'd2,
    CFG_S1 = 3'd3,
    CFG_S2 = 3'd4,
    CFG_T0 = 3'd5,
    CFG_T1 = 3'd6,
    CFG_T2 = 3'd7
  } cfg_idx_t;

  // Datapath action of one microcode step
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_SHIFT    = 4'd1,
    OP_LOADU    = 4'd2,
    OP_ABS      = 4'd3,
    OP_DIVLD    = 4'd4,
    OP_DIVIT    = 4'd5,
    OP_STEPOUT  = 4'd6,
    OP_FAULTOUT = 4'd7,
    OP_REFOUT   = 4'd8
  } op_t;

  // Sequencing of one microcode step
  typedef enum logic [2:0] {
    C_SEQ  = 3'd0,
    C_LOOP = 3'd1,
    C_T0Z  = 3'd2,
    C_OVF  = 3'd3,
    C_END  = 3'd4
  } cond_t;

  // Multiplier operand pair
  typedef enum logic [3:0] {
    SEL_T0R0  = 4'd0,
    SEL_T1R1  = 4'd1,
    SEL_T2R2  = 4'd2,
    SEL_R0M0  = 4'd3,
    SEL_R1M1  = 4'd4,
    SEL_R2M2  = 4'd5,
    SEL_S1U1  = 4'd6,
    SEL_S2U2  = 4'd7,
    SEL_ONEU0 = 4'd8
  } sel_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic            mul_en;
    sel_t            sel;
    logic            acc_en;
    logic            acc_neg;
    logic            acc_clr;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic acc_neg;
  } mac_ctrl_t;

  typedef struct packed {
    logic abs_ld;
    logic div_ld;
    logic div_it;
  } div_ctrl_t;

  localparam logic [PC_W-1:0] PC_STEP   = 5'd0;
  localparam logic [PC_W-1:0] PC_CLIP   = 5'd16;
  localparam logic [PC_W-1:0] PC_DIVIT  = 5'd28;
  localparam logic [PC_W-1:0] PC_REFOUT = 5'd29;
  localparam logic [PC_W-1:0] PC_FAULT  = 5'd30;

  function automatic uword_t uw(input op_t op, input cond_t cond, input logic mul_en,
                                input sel_t sel, input logic acc_en, input logic acc_neg,
                                input logic acc_clr, input logic [PC_W-1:0] target);
    uword_t w;
    w.op      = op;
    w.cond    = cond;
    w.mul_en  = mul_en;
    w.sel     = sel;
    w.acc_en  = acc_en;
    w.acc_neg = acc_neg;
    w.acc_clr = acc_clr;
    w.target  = target;
    return w;
  endfunction

  // Control store. A step that accumulates adds or subtracts the product issued by the step before.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      // control step: shift histories, then T*ref - R*meas - S*u
      5'd0:  w = uw(OP_SHIFT,    C_SEQ,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b1, PC_STEP);
      5'd1:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_STEP);
      5'd2:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_T1R1,  1'b1, 1'b0, 1'b0, PC_STEP);
      5'd3:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_T2R2,  1'b1, 1'b0, 1'b0, PC_STEP);
      5'd4:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R0M0,  1'b1, 1'b0, 1'b0, PC_STEP);
      5'd5:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R1M1,  1'b1, 1'b1, 1'b0, PC_STEP);
      5'd6:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R2M2,  1'b1, 1'b1, 1'b0, PC_STEP);
      5'd7:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_S1U1,  1'b1, 1'b1, 1'b0, PC_STEP);
      5'd8:  w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_S2U2,  1'b1, 1'b1, 1'b0, PC_STEP);
      5'd9:  w = uw(OP_NOP,      C_SEQ,  1'b0, SEL_T0R0,  1'b1, 1'b1, 1'b0, PC_STEP);
      5'd10: w = uw(OP_STEPOUT,  C_END,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_STEP);
      // clip command: load applied actuation, form numerator, divide by t0 (fault if t0 is zero)
      5'd16: w = uw(OP_LOADU,    C_SEQ,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b1, PC_CLIP);
      5'd17: w = uw(OP_NOP,      C_T0Z,  1'b1, SEL_ONEU0, 1'b0, 1'b0, 1'b0, PC_FAULT);
      5'd18: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R0M0,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd19: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R1M1,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd20: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_R2M2,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd21: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_S1U1,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd22: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_S2U2,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd23: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_T1R1,  1'b1, 1'b0, 1'b0, PC_CLIP);
      5'd24: w = uw(OP_NOP,      C_SEQ,  1'b1, SEL_T2R2,  1'b1, 1'b1, 1'b0, PC_CLIP);
      5'd25: w = uw(OP_NOP,      C_SEQ,  1'b0, SEL_T0R0,  1'b1, 1'b1, 1'b0, PC_CLIP);
      5'd26: w = uw(OP_ABS,      C_SEQ,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_CLIP);
      5'd27: w = uw(OP_DIVLD,    C_OVF,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_REFOUT);
      5'd28: w = uw(OP_DIVIT,    C_LOOP, 1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_DIVIT);
      5'd29: w = uw(OP_REFOUT,   C_END,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_CLIP);
      5'd30: w = uw(OP_FAULTOUT, C_END,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_CLIP);
      default: w = uw(OP_NOP,    C_END,  1'b0, SEL_T0R0,  1'b0, 1'b0, 1'b0, PC_STEP);
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rstc2_if.sv
// Valid/ready channel interfaces of the RST regulator: command in, result out.
// Plain logic payloads; no package needed.
`timescale 1ns / 1ps

interface rstc2_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] measurement;
  logic signed [31:0] reference;
  logic signed [31:0] applied_actuation;

  modport source (output valid, output cmd, output measurement, output reference,
                  output applied_actuation, input ready);
  modport sink   (input valid, input cmd, input measurement, input reference,
                  input applied_actuation, output ready);
endinterface

interface rstc2_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] actuation;
  logic signed [31:0] corrected_reference;
  logic               fault;

  modport source (output valid, output actuation, output corrected_reference,
                  output fault, input ready);
  modport sink   (input valid, input actuation, input corrected_reference,
                  input fault, output ready);
endinterface

>>> hw/rtl/rst_controller_order_two_core.sv
// Top level of the second-order RST regulator: microcode sequencer,
// histories, coefficient registers and output register.
// Depends on rstc2_pkg, rstc2_if, rstc2_mac and rstc2_div.
`timescale 1ns / 1ps
//
// Usage
//   in_ch carries one command word: cmd 0 is a control step (measurement and
//   reference), cmd 1 a clip command (applied_actuation). Every command word
//   yields exactly one result word on out_ch.
//   Coefficients are written through cfg_we/cfg_index/cfg_data while idle.
//   Work runs from a microcode table, one control word per cycle except while
//   the final word waits for the output register, through one shared multiplier
//   and accumulator and a one-bit-per-cycle divider. A clip command runs a
//   32-step divide loop, skipped when the quotient saturates early; when t0 is
//   zero it ends with a fault without dividing. A control step and a clip
//   command each run eight multiply steps. One command is in work at a time;
//   the next is accepted as soon as the previous one's last control word has run.
//   A result waits in the output register while out_ch.ready is low; a new
//   command may be accepted meanwhile, and its final step holds until the
//   register is free.
//   Reset (rst_n low, synchronous) clears histories to zero, coefficients to
//   zero with t0 = 1.0, and drops any pending result.

module rst_controller_order_two_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  rstc2_in_if.sink                                in_ch,
  rstc2_out_if.source                             out_ch,
  input  logic                                    cfg_we,
  input  logic [rstc2_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [rstc2_pkg::SIG_W-1:0]      cfg_data
);
  import rstc2_pkg::*;

  localparam logic signed [SIG_W-1:0] SMAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SMIN = {1'b1, {(SIG_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W-1);
  localparam logic signed [ACC_W-1:0] HI_MAX = ACC_W'(SMAX);
  localparam logic signed [ACC_W-1:0] HI_MIN = ACC_W'(SMIN);

  // coefficients
  logic signed [SIG_W-1:0] r_coeff_r [HIST_DEPTH];
  logic signed [SIG_W-1:0] t_coeff_r [HIST_DEPTH];
  logic signed [SIG_W-1:0] s1_coeff_r;
  logic signed [SIG_W-1:0] s2_coeff_r;

  // histories, index 0 newest
  logic signed [SIG_W-1:0] meas_r [HIST_DEPTH];
  logic signed [SIG_W-1:0] ref_r  [HIST_DEPTH];
  logic signed [SIG_W-1:0] act_r  [HIST_DEPTH];

  // captured command word
  logic signed [SIG_W-1:0] in_meas_r;
  logic signed [SIG_W-1:0] in_ref_r;
  logic signed [SIG_W-1:0] in_app_r;

  // sequencer
  logic                busy_r;
  logic [PC_W-1:0]     pc_r;
  logic [PC_W-1:0]     pc_nxt;
  logic [CNT_W-1:0]    cnt_r;
  uword_t              uw_cur;
  logic                out_free;
  logic                stall;
  logic                exe;
  logic                in_acc;

  // output register
  logic                    out_valid_r;
  logic signed [SIG_W-1:0] out_act_r;
  logic signed [SIG_W-1:0] out_cref_r;
  logic                    out_fault_r;

  // datapath
  mac_ctrl_t               mac_ctrl;
  div_ctrl_t               div_ctrl;
  logic signed [SIG_W-1:0] op_a;
  logic signed [SIG_W-1:0] op_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [SIG_W-1:0] div_res;
  logic                    div_ovf;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] rnd_hi;
  logic signed [SIG_W-1:0] step_u;
  logic                    t0_zero;

  assign uw_cur   = ucode(pc_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign stall    = (uw_cur.cond == C_END) && !out_free;
  assign exe      = busy_r && !stall;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign t0_zero  = (t_coeff_r[0] == '0);

  assign in_ch.ready = !busy_r;

  assign out_ch.valid               = out_valid_r;
  assign out_ch.actuation           = out_act_r;
  assign out_ch.corrected_reference = out_cref_r;
  assign out_ch.fault               = out_fault_r;

  // decode control word into unit controls
  always_comb begin
    mac_ctrl.mul_en  = exe && uw_cur.mul_en;
    mac_ctrl.acc_clr = exe && uw_cur.acc_clr;
    mac_ctrl.acc_en  = exe && uw_cur.acc_en;
    mac_ctrl.acc_neg = uw_cur.acc_neg;
    div_ctrl.abs_ld  = exe && (uw_cur.op == OP_ABS);
    div_ctrl.div_ld  = exe && (uw_cur.op == OP_DIVLD);
    div_ctrl.div_it  = exe && (uw_cur.op == OP_DIVIT);
  end

  // select multiplier operands
  always_comb begin
    case (uw_cur.sel)
      SEL_T0R0:  begin op_a = t_coeff_r[0]; op_b = ref_r[0];  end
      SEL_T1R1:  begin op_a = t_coeff_r[1]; op_b = ref_r[1];  end
      SEL_T2R2:  begin op_a = t_coeff_r[2]; op_b = ref_r[2];  end
      SEL_R0M0:  begin op_a = r_coeff_r[0]; op_b = meas_r[0]; end
      SEL_R1M1:  begin op_a = r_coeff_r[1]; op_b = meas_r[1]; end
      SEL_R2M2:  begin op_a = r_coeff_r[2]; op_b = meas_r[2]; end
      SEL_S1U1:  begin op_a = s1_coeff_r;   op_b = act_r[1];  end
      SEL_S2U2:  begin op_a = s2_coeff_r;   op_b = act_r[2];  end
      SEL_ONEU0: begin op_a = FRAC_ONE;     op_b = act_r[0];  end
      default:   begin op_a = '0;           op_b = '0;        end
    endcase
  end

  rstc2_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  rstc2_div u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (acc),
    .den  (t_coeff_r[0]),
    .res  (div_res),
    .ovf  (div_ovf)
  );

  // round Q.40 sum to Q16.16, ties up, then saturate
  always_comb begin
    rnd    = acc + HALF;
    rnd_hi = rnd >>> FRAC_W;
    if (rnd_hi > HI_MAX) begin
      step_u = SMAX;
    end else if (rnd_hi < HI_MIN) begin
      step_u = SMIN;
    end else begin
      step_u = rnd_hi[SIG_W-1:0];
    end
  end

  // next step address
  always_comb begin
    case (uw_cur.cond)
      C_SEQ:   pc_nxt = pc_r + PC_W'(1);
      C_LOOP:  pc_nxt = (cnt_r != '0) ? uw_cur.target : pc_r + PC_W'(1);
      C_T0Z:   pc_nxt = t0_zero ? uw_cur.target : pc_r + PC_W'(1);
      C_OVF:   pc_nxt = div_ovf ? uw_cur.target : pc_r + PC_W'(1);
      default: pc_nxt = pc_r;
    endcase
  end

  // sequencer: start on accept, advance, go idle on the final word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_STEP;
      cnt_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      pc_r   <= (in_ch.cmd == CMD_CLIP) ? PC_CLIP : PC_STEP;
    end else if (exe) begin
      if (uw_cur.cond == C_END) begin
        busy_r <= 1'b0;
      end
      pc_r <= pc_nxt;
      if (uw_cur.op == OP_DIVLD) begin
        cnt_r <= CNT_W'(DIV_BITS - 1);
      end else if (uw_cur.op == OP_DIVIT) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // capture command payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_meas_r <= in_ch.measurement;
      in_ref_r  <= in_ch.reference;
      in_app_r  <= in_ch.applied_actuation;
    end
  end

  // coefficient writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_coeff_r[0] <= '0;
      r_coeff_r[1] <= '0;
      r_coeff_r[2] <= '0;
      s1_coeff_r   <= '0;
      s2_coeff_r   <= '0;
      t_coeff_r[0] <= T0_RESET;
      t_coeff_r[1] <= '0;
      t_coeff_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_R0:  r_coeff_r[0] <= cfg_data;
        CFG_R1:  r_coeff_r[1] <= cfg_data;
        CFG_R2:  r_coeff_r[2] <= cfg_data;
        CFG_S1:  s1_coeff_r   <= cfg_data;
        CFG_S2:  s2_coeff_r   <= cfg_data;
        CFG_T0:  t_coeff_r[0] <= cfg_data;
        CFG_T1:  t_coeff_r[1] <= cfg_data;
        CFG_T2:  t_coeff_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // history updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        meas_r[i] <= '0;
        ref_r[i]  <= '0;
        act_r[i]  <= '0;
      end
    end else if (exe) begin
      case (uw_cur.op)
        OP_SHIFT: begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            meas_r[i] <= meas_r[i-1];
            ref_r[i]  <= ref_r[i-1];
            act_r[i]  <= act_r[i-1];
          end
          meas_r[0] <= in_meas_r;
          ref_r[0]  <= in_ref_r;
        end
        OP_LOADU:   act_r[0] <= in_app_r;
        OP_STEPOUT: act_r[0] <= step_u;
        OP_REFOUT:  ref_r[0] <= div_res;
        default: ;
      endcase
    end
  end

  // output register: load on the final word, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exe && (uw_cur.cond == C_END) &&
                 ((uw_cur.op == OP_STEPOUT) || (uw_cur.op == OP_REFOUT) ||
                  (uw_cur.op == OP_FAULTOUT))) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exe) begin
      case (uw_cur.op)
        OP_STEPOUT: begin
          out_act_r   <= step_u;
          out_cref_r  <= '0;
          out_fault_r <= 1'b0;
        end
        OP_REFOUT: begin
          out_act_r   <= '0;
          out_cref_r  <= div_res;
          out_fault_r <= 1'b0;
        end
        OP_FAULTOUT: begin
          out_act_r   <= '0;
          out_cref_r  <= ref_r[0];
          out_fault_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/rstc2_mac.sv
// Multiply-accumulate unit: one registered 32x32 signed multiplier and an
// exact 68-bit accumulator. Uses rstc2_pkg for widths and the control struct.
`timescale 1ns / 1ps

module rstc2_mac (
  input  logic                                clk,
  input  rstc2_pkg::mac_ctrl_t                ctrl,
  input  logic signed [rstc2_pkg::SIG_W-1:0]  op_a,
  input  logic signed [rstc2_pkg::SIG_W-1:0]  op_b,
  output logic signed [rstc2_pkg::ACC_W-1:0]  acc
);
  import rstc2_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  // sign-extend product into accumulator width
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // register the product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // clear or add/subtract the previous product
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      if (ctrl.acc_neg) begin
        acc_r <= acc_r - prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  assign acc = acc_r;

endmodule

>>> hw/rtl/rstc2_div.sv
// Back-calculation divider: magnitudes, overflow test and a restoring
// divide producing one quotient bit per cycle, with signed saturation.
// Uses rstc2_pkg for widths and the control struct.
`timescale 1ns / 1ps

module rstc2_div (
  input  logic                                clk,
  input  rstc2_pkg::div_ctrl_t                ctrl,
  input  logic signed [rstc2_pkg::ACC_W-1:0]  num,
  input  logic signed [rstc2_pkg::SIG_W-1:0]  den,
  output logic signed [rstc2_pkg::SIG_W-1:0]  res,
  output logic                                ovf
);
  import rstc2_pkg::*;

  localparam logic signed [SIG_W-1:0] SMAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SMIN = {1'b1, {(SIG_W-1){1'b0}}};

  logic [ACC_W-1:0]    mag_r;
  logic [SIG_W-1:0]    dmag_r;
  logic                neg_r;
  logic [DIV_BITS-1:0] quot_r;
  logic [SIG_W-1:0]    rem_r;
  logic [SIG_W:0]      trial;
  logic                ge;
  logic                q_big;

  // quotient would not fit 32 bits when the upper numerator reaches the divisor
  assign ovf   = mag_r[ACC_W-1:DIV_BITS] >= (ACC_W-DIV_BITS)'(dmag_r);
  assign trial = {rem_r, quot_r[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dmag_r};

  // take magnitudes and result sign
  always_ff @(posedge clk) begin
    if (ctrl.abs_ld) begin
      mag_r  <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      dmag_r <= den[SIG_W-1] ? SIG_W'(-den) : SIG_W'(den);
      neg_r  <= num[ACC_W-1] ^ den[SIG_W-1];
    end
  end

  // load partial remainder, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctrl.div_ld) begin
      rem_r  <= mag_r[DIV_BITS +: SIG_W];
      quot_r <= mag_r[DIV_BITS-1:0];
    end else if (ctrl.div_it) begin
      if (ge) begin
        rem_r <= SIG_W'(trial - {1'b0, dmag_r});
      end else begin
        rem_r <= trial[SIG_W-1:0];
      end
      quot_r <= {quot_r[DIV_BITS-2:0], ge};
    end
  end

  // saturate the truncated quotient to the signed range
  always_comb begin
    if (neg_r) begin
      q_big = ovf || (quot_r[DIV_BITS-1] && (|quot_r[DIV_BITS-2:0]));
      res   = q_big ? SMIN : SIG_W'(-quot_r);
    end else begin
      q_big = ovf || quot_r[DIV_BITS-1];
      res   = q_big ? SMAX : SIG_W'(quot_r);
    end
  end

endmodule

>>> sim/tb_top.sv
// Self-checking bench for the second-order RST regulator core.
// Holds a bit-exact predictor in a small scoreboard class and drives the
// valid/ready channels and coefficient port; depends on rstc2_pkg, rstc2_if and the core.
`timescale 1ns / 1ps

module tb_top;
  import rstc2_pkg::*;

  typedef logic signed [SIG_W-1:0] sig_t;
  // exact Q24.40 sums need well under 72 bits
  typedef logic signed [71:0] wide_t;
  typedef sig_t coeff_set_t [8];

  typedef struct packed {
    logic signed [SIG_W-1:0] actuation;
    logic signed [SIG_W-1:0] corrected_reference;
    logic                    fault;
  } reg_result_t;

  localparam int          SETTLE_CYCLES = 48;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          RANDOM_PHASES = 7;
  localparam int          WORDS_PER_PHASE = 150;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  localparam sig_t SIG_MAX = 32'sh7fff_ffff;
  localparam sig_t SIG_MIN = 32'sh8000_0000;

  // Tracks regulator state and coefficients, queues and checks result words
  class regulator_scoreboard;
    sig_t        coeff_r[3];
    sig_t        coeff_s[3];
    sig_t        coeff_t[3];
    sig_t        hist_meas[3];
    sig_t        hist_ref[3];
    sig_t        hist_act[3];
    reg_result_t awaited_results[$];
    int unsigned mismatches;

    function new();
      int i;
      for (i = 0; i < HIST_DEPTH; i++) begin
        coeff_r[i]   = '0;
        coeff_s[i]   = '0;
        coeff_t[i]   = '0;
        hist_meas[i] = '0;
        hist_ref[i]  = '0;
        hist_act[i]  = '0;
      end
      coeff_t[0] = T0_RESET;
      mismatches = 0;
    endfunction

    function wide_t mul(sig_t a, sig_t b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    function sig_t sat(wide_t v);
      if (v > 72'sd2147483647) return SIG_MAX;
      if (v < -72'sd2147483648) return SIG_MIN;
      return v[SIG_W-1:0];
    endfunction

    function void write_coeff(cfg_idx_t idx, sig_t val);
      case (idx)
        CFG_R0: coeff_r[0] = val;
        CFG_R1: coeff_r[1] = val;
        CFG_R2: coeff_r[2] = val;
        CFG_S1: coeff_s[1] = val;
        CFG_S2: coeff_s[2] = val;
        CFG_T0: coeff_t[0] = val;
        CFG_T1: coeff_t[1] = val;
        CFG_T2: coeff_t[2] = val;
        default: ;
      endcase
    endfunction

    // Update the histories for one command word and return its result word
    function reg_result_t advance_regulator(cmd_t cmd, sig_t meas, sig_t ref_in,
                                            sig_t applied);
      reg_result_t res;
      wide_t       acc;
      wide_t       divisor;
      int          i;
      res = '0;
      acc = '0;
      if (cmd == CMD_STEP) begin
        for (i = HIST_DEPTH - 1; i > 0; i--) begin
          hist_meas[i] = hist_meas[i-1];
          hist_ref[i]  = hist_ref[i-1];
          hist_act[i]  = hist_act[i-1];
        end
        hist_meas[0] = meas;
        hist_ref[0]  = ref_in;
        for (i = 0; i < HIST_DEPTH; i++)
          acc = acc + mul(coeff_t[i], hist_ref[i]) - mul(coeff_r[i], hist_meas[i]);
        acc = acc - mul(coeff_s[1], hist_act[1]) - mul(coeff_s[2], hist_act[2]);
        // round half up from Q.40 to Q.16, then saturate
        hist_act[0]   = sat((acc + 72'sd8388608) >>> FRAC_W);
        res.actuation = hist_act[0];
      end else begin
        hist_act[0] = applied;
        if (coeff_t[0] == '0) begin
          res.corrected_reference = hist_ref[0];
          res.fault = 1'b1;
        end else begin
          acc = mul(hist_act[0], FRAC_ONE);
          for (i = 0; i < HIST_DEPTH; i++)
            acc = acc + mul(coeff_r[i], hist_meas[i]);
          acc = acc + mul(coeff_s[1], hist_act[1]) + mul(coeff_s[2], hist_act[2]);
          acc = acc - mul(coeff_t[1], hist_ref[1]) - mul(coeff_t[2], hist_ref[2]);
          divisor = coeff_t[0];
          // signed division truncates toward zero
          hist_ref[0] = sat(acc / divisor);
          res.corrected_reference = hist_ref[0];
        end
      end
      return res;
    endfunction

    function void note_command(cmd_t cmd, sig_t meas, sig_t ref_in, sig_t applied);
      awaited_results.push_back(advance_regulator(cmd, meas, ref_in, applied));
    endfunction

    function void check_result(sig_t act, sig_t cref, logic fault);
      reg_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word: actuation %0d corrected_reference %0d fault %0b",
                 $time, act, cref, fault);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (act !== want.actuation) begin
        $display("%0t: actuation expected %0d actual %0d", $time, want.actuation, act);
        mismatches++;
      end
      if (cref !== want.corrected_reference) begin
        $display("%0t: corrected_reference expected %0d actual %0d", $time,
                 want.corrected_reference, cref);
        mismatches++;
      end
      if (fault !== want.fault) begin
        $display("%0t: fault expected %0b actual %0b", $time, want.fault, fault);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  sig_t     cfg_data;

  int unsigned         cycle_count = 0;
  int                  burst_left  = 0;
  regulator_scoreboard board       = new();

  rstc2_in_if  in_ch ();
  rstc2_out_if out_ch ();

  rst_controller_order_two_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.actuation, out_ch.corrected_reference, out_ch.fault);
  end

  // Stall the result channel: free-flowing, light and heavy stretches
  initial begin : result_drain
    int stall_mode;
    int span;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall_mode = $urandom_range(0, 2);
      span = $urandom_range(16, 240);
      repeat (span) begin
        @(negedge clk);
        case (stall_mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 3) != 0);
          default: out_ch.ready = ($urandom_range(0, 11) == 0);
        endcase
      end
    end
  end

  function automatic sig_t rand_signal();
    sig_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 2**21);
        v = v - 32'sd1048576;
      end
      4, 5, 6: begin
        v = $urandom_range(0, 2**29);
        v = v - 32'sd268435456;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       v = SIG_MAX;
          1:       v = SIG_MIN;
          2:       v = '0;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Coefficient within +/-2.0 in Q8.24
  function automatic sig_t rand_gain();
    sig_t v;
    v = $urandom_range(0, 2**26);
    return v - 32'sd33554432;
  endfunction

  function automatic sig_t clamp_actuation(sig_t u, sig_t lim);
    if (u > lim) return lim;
    if (u < -lim) return -lim;
    return u;
  endfunction

  function automatic coeff_set_t build_coeffs(int mode);
    coeff_set_t c;
    sig_t       mag;
    foreach (c[i]) begin
      case (mode)
        1:       c[i] = $urandom;
        2:       c[i] = SIG_MAX;
        3:       c[i] = SIG_MIN;
        default: c[i] = rand_gain();
      endcase
    end
    mag = $urandom_range(2**22, 2**25);
    case (mode)
      0:       c[CFG_T0] = mag;
      4:       c[CFG_T0] = '0;
      5:       c[CFG_T0] = -mag;
      6: begin
        mag = $urandom_range(1, 255);
        c[CFG_T0] = $urandom_range(0, 1) ? mag : -mag;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Wait until every issued word has answered and the core has gone quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_coeffs(input coeff_set_t coeffs);
    cfg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = idx;
      cfg_data  = coeffs[idx];
      board.write_coeff(idx, coeffs[idx]);
      idx = idx.next();
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send one command word, with bursts and gaps on the input side
  task automatic issue(cmd_t cmd, sig_t meas, sig_t ref_in, sig_t applied);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid             = 1'b0;
        in_ch.cmd               = $urandom_range(0, 1);
        in_ch.measurement       = $urandom;
        in_ch.reference         = $urandom;
        in_ch.applied_actuation = $urandom;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid             = 1'b1;
    in_ch.cmd               = cmd;
    in_ch.measurement       = meas;
    in_ch.reference         = ref_in;
    in_ch.applied_actuation = applied;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_command(cmd, meas, ref_in, applied);
  endtask

  // Mostly step-then-clip loops with random content, the rest noise
  task automatic random_commands(int count);
    int   sent;
    sig_t lim;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        issue(CMD_STEP, rand_signal(), rand_signal(), $urandom);
        sent++;
        if ($urandom_range(0, 1) && sent < count) begin
          lim = $urandom_range(2**16, 2**24);
          issue(CMD_CLIP, $urandom, $urandom, clamp_actuation(board.hist_act[0], lim));
          sent++;
        end
      end else begin
        issue(cmd_t'($urandom_range(0, 1)), rand_signal(), rand_signal(), rand_signal());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    coeff_set_t set;
    int         phase;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_R0;
    cfg_data                = '0;
    in_ch.valid             = 1'b0;
    in_ch.cmd               = CMD_STEP;
    in_ch.measurement       = '0;
    in_ch.reference         = '0;
    in_ch.applied_actuation = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset coefficients: t0 = 1.0, rest zero
    issue(CMD_STEP, '0, '0, $urandom);
    issue(CMD_STEP, SIG_MAX, SIG_MAX, $urandom);
    issue(CMD_STEP, SIG_MIN, SIG_MIN, $urandom);
    issue(CMD_STEP, -32'sd1, 32'sd1, $urandom);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MAX);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MIN);
    issue(CMD_CLIP, $urandom, $urandom, '0);
    issue(CMD_STEP, 32'sh1234_5678, -32'sd1, $urandom);

    // Zero divisor: clip raises fault and keeps the reference
    settle();
    set = '{default: '0};
    program_coeffs(set);
    issue(CMD_CLIP, $urandom, $urandom, 32'sd5);
    issue(CMD_STEP, $urandom, SIG_MAX, $urandom);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MIN);

    // Alternating full-scale coefficients drive both saturation limits
    settle();
    set = '{SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX};
    program_coeffs(set);
    issue(CMD_STEP, SIG_MAX, SIG_MIN, $urandom);
    issue(CMD_STEP, SIG_MIN, SIG_MAX, $urandom);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MAX);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MIN);

    // Divisor of -1 LSB: quotient overflows early
    settle();
    set = '{default: '0};
    set[CFG_T0] = -32'sd1;
    program_coeffs(set);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MAX);
    issue(CMD_CLIP, $urandom, $urandom, SIG_MIN);
    issue(CMD_STEP, $urandom, 32'sd65536, $urandom);

    // One-LSB gain: rounding ties go toward plus infinity
    settle();
    set[CFG_T0] = 32'sd1;
    program_coeffs(set);
    issue(CMD_STEP, $urandom, 32'sd8388608, $urandom);
    issue(CMD_STEP, $urandom, -32'sd8388608, $urandom);
    issue(CMD_STEP, $urandom, -32'sd8388609, $urandom);

    // Random phases, each under a new coefficient set
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      program_coeffs(build_coeffs(phase));
      random_commands(WORDS_PER_PHASE);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.awaited_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> rst_controller_order_two_core.f
hw/rtl/rstc2_pkg.sv
hw/rtl/rstc2_if.sv
hw/rtl/rstc2_mac.sv
hw/rtl/rstc2_div.sv
hw/rtl/rst_controller_order_two_core.sv
sim/tb_top.sv
